### design/tgrf_pkg.sv
// Shared types, codes and constants for the touch glove rejection filter.
`default_nettype none

package tgrf_pkg;

    // Default slot counts
    localparam int SLOTS_DEF          = 10;
    localparam int FILTERED_SLOTS_DEF = 4;

    // Field widths
    localparam int SLOT_W     = 4;
    localparam int POS_W      = 16;
    localparam int PRESS_W    = 16;
    localparam int TIME_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register reset values
    localparam logic [15:0] WINDOW_RST    = 16'd500;
    localparam logic [15:0] THRESHOLD_RST = 16'd30;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOLSTER = 2'd0,
        CFG_WINDOW  = 2'd1,
        CFG_THRESH  = 2'd2
    } cfg_idx_t;

    // Pad-wide contact mode
    typedef enum logic [1:0] {
        MODE_INIT   = 2'd0,
        MODE_FINGER = 2'd1,
        MODE_ZERO   = 2'd2,
        MODE_GLOVE  = 2'd3
    } mode_t;

    // Result status codes
    localparam logic [1:0] ST_NONE    = 2'd0;
    localparam logic [1:0] ST_PRESS   = 2'd1;
    localparam logic [1:0] ST_RELEASE = 2'd2;

    // Contact kinds
    localparam logic [1:0] KIND_FINGER  = 2'd0;
    localparam logic [1:0] KIND_GLOVE   = 2'd1;
    localparam logic [1:0] KIND_STYLUS  = 2'd2;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    // Configuration register file
    typedef struct packed {
        logic        holster_on;
        logic [15:0] window;
        logic [15:0] threshold;
    } cfg_t;

    // Stored state of one filtered slot
    typedef struct packed {
        logic              anchor_valid;
        logic [POS_W-1:0]  anchor_x;
        logic [POS_W-1:0]  anchor_y;
        logic [TIME_W-1:0] release_time;
    } slot_state_t;

    // Decision for one filtered contact
    typedef struct packed {
        logic  report;
        mode_t mode_next;
        logic  stamp_release;
        logic  latch_anchor;
    } judge_t;

endpackage

`default_nettype wire

### design/tgrf_judge.sv
// Decision logic for a glove or finger contact in a filtered slot.
`default_nettype none

module tgrf_judge (
    input  var tgrf_pkg::cfg_t                cfg,
    input  var tgrf_pkg::mode_t               mode,
    input  var tgrf_pkg::slot_state_t         cur,
    input  wire logic [tgrf_pkg::POS_W-1:0]   pos_x,
    input  wire logic [tgrf_pkg::POS_W-1:0]   pos_y,
    input  wire logic [1:0]                   contact_kind,
    input  wire logic [tgrf_pkg::TIME_W-1:0]  time_ms,
    output tgrf_pkg::judge_t                  decision
);
    import tgrf_pkg::*;

    logic [TIME_W-1:0] elapsed;
    logic              in_window;
    logic [POS_W-1:0]  dx;
    logic [POS_W-1:0]  dy;
    logic [31:0]       dx_sq;
    logic [31:0]       dy_sq;
    logic [32:0]       dist_sq;
    logic [31:0]       thr_sq;
    logic              moved_far;

    // Time since last release, wrapped and read as signed: positive and within window
    assign elapsed   = time_ms - cur.release_time;
    assign in_window = (elapsed != '0) && !elapsed[TIME_W-1]
                       && (elapsed <= {16'd0, cfg.window});

    // Squared movement from the anchor against squared threshold
    assign dx      = (cur.anchor_x > pos_x) ? cur.anchor_x - pos_x : pos_x - cur.anchor_x;
    assign dy      = (cur.anchor_y > pos_y) ? cur.anchor_y - pos_y : pos_y - cur.anchor_y;
    assign dx_sq   = dx * dx;
    assign dy_sq   = dy * dy;
    assign dist_sq = {1'b0, dx_sq} + {1'b0, dy_sq};
    assign thr_sq  = cfg.threshold * cfg.threshold;
    assign moved_far = dist_sq >= {1'b0, thr_sq};

    // Mode transitions
    always_comb
    begin
        decision.report        = 1'b1;
        decision.mode_next     = mode;
        decision.stamp_release = 1'b0;
        decision.latch_anchor  = 1'b0;
        if (contact_kind == KIND_FINGER || cfg.holster_on)
        begin
            decision.mode_next = MODE_FINGER;
        end
        else if (contact_kind != KIND_UNKNOWN)
        begin
            unique case (mode)
                MODE_INIT:
                begin
                    decision.mode_next = MODE_GLOVE;
                end
                MODE_FINGER:
                begin
                    decision.report = 1'b0;
                    if (in_window)
                        decision.stamp_release = 1'b1;
                    else
                        decision.mode_next = MODE_ZERO;
                end
                MODE_ZERO:
                begin
                    decision.report = 1'b0;
                    if (!cur.anchor_valid)
                        decision.latch_anchor = 1'b1;
                    else if (moved_far)
                        decision.mode_next = MODE_GLOVE;
                end
                MODE_GLOVE:
                begin
                    decision.report = 1'b1;
                end
                default:
                begin
                    decision.report = 1'b1;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### design/touch_glove_rejection_filter.sv
// Top level of the touch glove rejection filter.
// An accepted input beat reaches its first result beat through the input register,
// then the result register. Throughput: one contact beat per cycle while the
// result channel is not stalled; a release beat yields SLOTS result beats, one per
// cycle while not stalled, and holds the input register until its last is loaded.
// Reset (rst_n low, asynchronous): registers to defaults, pad mode init,
// no anchors, release times zero, both channels empty.
`default_nettype none

module touch_glove_rejection_filter #(
    parameter int SLOTS          = tgrf_pkg::SLOTS_DEF,
    parameter int FILTERED_SLOTS = tgrf_pkg::FILTERED_SLOTS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration write port
    input  wire logic                              cfg_we,
    input  wire logic [tgrf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tgrf_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input channel
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              action,
    input  wire logic [tgrf_pkg::SLOT_W-1:0]       slot,
    input  wire logic [tgrf_pkg::POS_W-1:0]        pos_x,
    input  wire logic [tgrf_pkg::POS_W-1:0]        pos_y,
    input  wire logic [tgrf_pkg::PRESS_W-1:0]      pressure,
    input  wire logic [1:0]                        contact_kind,
    input  wire logic [tgrf_pkg::TIME_W-1:0]       time_ms,
    // result channel
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [tgrf_pkg::SLOT_W-1:0]            out_slot,
    output logic [tgrf_pkg::POS_W-1:0]             out_x,
    output logic [tgrf_pkg::POS_W-1:0]             out_y,
    output logic [tgrf_pkg::PRESS_W-1:0]           out_pressure,
    output logic [1:0]                             status,
    output logic                                   last
);
    import tgrf_pkg::*;

    localparam int FIDX_W = (FILTERED_SLOTS > 1) ? $clog2(FILTERED_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    // Configuration registers
    cfg_t cfg_reg;

    // Input register
    logic               s1_valid_reg;
    logic               s1_action_reg;
    logic [SLOT_W-1:0]  s1_slot_reg;
    logic [POS_W-1:0]   s1_x_reg;
    logic [POS_W-1:0]   s1_y_reg;
    logic [PRESS_W-1:0] s1_p_reg;
    logic [1:0]         s1_kind_reg;
    logic [TIME_W-1:0]  s1_time_reg;

    // Release sequence counter
    logic [SLOT_W-1:0]  rel_idx_reg;
    logic [SLOT_W-1:0]  rel_idx_next;

    // Pad and slot state
    mode_t              mode_reg;
    mode_t              mode_next;
    logic               anchor_valid_reg [FILTERED_SLOTS];
    logic [POS_W-1:0]   anchor_x_reg     [FILTERED_SLOTS];
    logic [POS_W-1:0]   anchor_y_reg     [FILTERED_SLOTS];
    logic [TIME_W-1:0]  release_time_reg [FILTERED_SLOTS];

    // Result register
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [SLOT_W-1:0]  out_slot_reg;
    logic [SLOT_W-1:0]  out_slot_next;
    logic [POS_W-1:0]   out_x_reg;
    logic [POS_W-1:0]   out_x_next;
    logic [POS_W-1:0]   out_y_reg;
    logic [POS_W-1:0]   out_y_next;
    logic [PRESS_W-1:0] out_p_reg;
    logic [PRESS_W-1:0] out_p_next;
    logic [1:0]         status_reg;
    logic [1:0]         status_next;
    logic               last_reg;
    logic               last_next;

    // Control
    logic               out_free;
    logic               fire;
    logic               rel_last;
    logic               consume;
    logic               in_take;
    logic               in_range;
    logic               filtered;
    logic               empty;
    logic               filt_hit;
    logic               reported;
    logic               rel_start;
    logic [FIDX_W-1:0]  fidx;
    slot_state_t        cur_state;
    judge_t             jd;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.holster_on <= 1'b0;
            cfg_reg.window     <= WINDOW_RST;
            cfg_reg.threshold  <= THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HOLSTER: cfg_reg.holster_on <= cfg_data[0];
                CFG_WINDOW:  cfg_reg.window     <= cfg_data;
                CFG_THRESH:  cfg_reg.threshold  <= cfg_data;
                default:     cfg_reg            <= cfg_reg;
            endcase
        end
    end

    // Handshake: the input register moves on once all its results are loaded
    assign out_free = !out_valid_reg || !out_stall;
    assign fire     = s1_valid_reg && out_free;
    assign rel_last = (rel_idx_reg == LAST_SLOT);
    assign consume  = fire && (!s1_action_reg || rel_last);
    assign in_stall = s1_valid_reg && !consume;
    assign in_take  = in_valid && !in_stall;

    // Contact classification
    assign in_range  = {1'b0, s1_slot_reg} < (SLOT_W + 1)'(SLOTS);
    assign filtered  = {1'b0, s1_slot_reg} < (SLOT_W + 1)'(FILTERED_SLOTS);
    assign empty     = (s1_x_reg == '0) && (s1_y_reg == '0);
    assign filt_hit  = !s1_action_reg && in_range && filtered && !empty;
    assign fidx      = s1_slot_reg[FIDX_W-1:0];
    assign rel_start = fire && s1_action_reg && (rel_idx_reg == '0);

    assign cur_state.anchor_valid = anchor_valid_reg[fidx];
    assign cur_state.anchor_x     = anchor_x_reg[fidx];
    assign cur_state.anchor_y     = anchor_y_reg[fidx];
    assign cur_state.release_time = release_time_reg[fidx];

    tgrf_judge u_judge (
        .cfg          (cfg_reg),
        .mode         (mode_reg),
        .cur          (cur_state),
        .pos_x        (s1_x_reg),
        .pos_y        (s1_y_reg),
        .contact_kind (s1_kind_reg),
        .time_ms      (s1_time_reg),
        .decision     (jd)
    );

    assign reported = !empty && (!filt_hit || jd.report);

    // Next mode and release counter
    always_comb
    begin
        mode_next    = mode_reg;
        rel_idx_next = rel_idx_reg;
        if (fire && filt_hit)
            mode_next = jd.mode_next;
        if (fire && s1_action_reg)
            rel_idx_next = rel_last ? '0 : rel_idx_reg + 1'b1;
    end

    // Result beat
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_slot_next  = out_slot_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_p_next     = out_p_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        if (out_free)
        begin
            out_valid_next = fire && (s1_action_reg || in_range);
            out_x_next     = '0;
            out_y_next     = '0;
            out_p_next     = '0;
            if (s1_action_reg)
            begin
                out_slot_next = rel_idx_reg;
                status_next   = (rel_idx_reg == '0) ? ST_RELEASE : ST_NONE;
                last_next     = rel_last;
            end
            else
            begin
                out_slot_next = s1_slot_reg;
                status_next   = reported ? ST_PRESS : ST_NONE;
                last_next     = 1'b1;
                if (reported)
                begin
                    out_x_next = s1_x_reg;
                    out_y_next = s1_y_reg;
                    out_p_next = s1_p_reg;
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rel_idx_reg   <= '0;
            mode_reg      <= MODE_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (consume)
                s1_valid_reg <= 1'b0;
            rel_idx_reg   <= rel_idx_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input payload and result payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_action_reg <= action;
            s1_slot_reg   <= slot;
            s1_x_reg      <= pos_x;
            s1_y_reg      <= pos_y;
            s1_p_reg      <= pressure;
            s1_kind_reg   <= contact_kind;
            s1_time_reg   <= time_ms;
        end
        out_slot_reg <= out_slot_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_p_reg    <= out_p_next;
        status_reg   <= status_next;
        last_reg     <= last_next;
    end

    // Per-slot anchor flags and release stamps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FILTERED_SLOTS; i++)
            begin
                anchor_valid_reg[i] <= 1'b0;
                release_time_reg[i] <= '0;
            end
        end
        else if (rel_start)
        begin
            for (int i = 0; i < FILTERED_SLOTS; i++)
            begin
                anchor_valid_reg[i] <= 1'b0;
                if (mode_reg == MODE_FINGER)
                    release_time_reg[i] <= s1_time_reg;
            end
        end
        else if (fire && filt_hit)
        begin
            if (jd.latch_anchor)
                anchor_valid_reg[fidx] <= 1'b1;
            if (jd.stamp_release)
                release_time_reg[fidx] <= s1_time_reg;
        end
    end

    // Anchor positions, meaningful only while their flag is set
    always_ff @(posedge clk)
    begin
        if (fire && filt_hit && jd.latch_anchor)
        begin
            anchor_x_reg[fidx] <= s1_x_reg;
            anchor_y_reg[fidx] <= s1_y_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_slot     = out_slot_reg;
    assign out_x        = out_x_reg;
    assign out_y        = out_y_reg;
    assign out_pressure = out_p_reg;
    assign status       = status_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

### design/tgrf_checker.sv
// Port-level checks on the result channel of the touch glove rejection filter.
`default_nettype none

module tgrf_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic [tgrf_pkg::SLOT_W-1:0]   out_slot,
    input wire logic [tgrf_pkg::POS_W-1:0]    out_x,
    input wire logic [tgrf_pkg::POS_W-1:0]    out_y,
    input wire logic [tgrf_pkg::PRESS_W-1:0]  out_pressure,
    input wire logic [1:0]                    status,
    input wire logic                          last
);
    import tgrf_pkg::*;

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_slot) && $stable(status)
                                   && $stable(last))
        else $error("result beat changed while stalled");

    // A release result always describes slot 0
    a_release_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_RELEASE |-> out_slot == '0)
        else $error("release result on a slot other than 0");

    // Only a press carries position and pressure
    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_PRESS |-> out_x == '0 && out_y == '0 && out_pressure == '0)
        else $error("non-press result with nonzero payload");

    // A release sequence runs without gaps over consecutive slots
    a_release_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid && out_slot == $past(out_slot) + 1'b1
                                             && status == ST_NONE)
        else $error("release sequence broken");

endmodule

bind touch_glove_rejection_filter tgrf_checker u_tgrf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_slot     (out_slot),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_pressure (out_pressure),
    .status       (status),
    .last         (last)
);

`default_nettype wire

### sim/tb_touch_glove_rejection_filter.sv
// Self-checking testbench for the touch glove rejection filter.
`timescale 1ns / 1ps

module tb_touch_glove_rejection_filter;
    import tgrf_pkg::*;

    localparam int NSLOTS = SLOTS_DEF;
    localparam int NFILT  = FILTERED_SLOTS_DEF;

    // Index with no register behind it; writes to it must be ignored
    localparam cfg_idx_t CFG_SPARE = cfg_idx_t'(2'd3);

    // One input beat
    typedef struct packed {
        logic        action;
        logic [3:0]  slot;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] p;
        logic [1:0]  kind;
        logic [31:0] t;
    } touch_beat_t;

    // One result beat
    typedef struct packed {
        logic [3:0]  slot;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] p;
        logic [1:0]  status;
        logic        last;
    } touch_result_t;

    // Tracks pad mode, anchors and release stamps; queues the results each beat causes
    class touch_filter_scoreboard;
        logic        holster;
        logic [15:0] window;
        logic [15:0] threshold;
        mode_t       pad_state;
        logic        anchor_ok [NFILT];
        logic [15:0] anchor_px [NFILT];
        logic [15:0] anchor_py [NFILT];
        logic [31:0] lift_time [NFILT];
        touch_result_t expected_results[$];
        int errors;
        int checked;
        int items;
        int releases;
        int presses;
        int suppressed;
        int to_glove;
        int to_zero;

        function new();
            holster   = 1'b0;
            window    = WINDOW_RST;
            threshold = THRESHOLD_RST;
            pad_state = MODE_INIT;
            for (int i = 0; i < NFILT; i++)
            begin
                anchor_ok[i] = 1'b0;
                anchor_px[i] = '0;
                anchor_py[i] = '0;
                lift_time[i] = '0;
            end
            errors = 0; checked = 0; items = 0; releases = 0;
            presses = 0; suppressed = 0; to_glove = 0; to_zero = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [15:0] data);
            case (idx)
                CFG_HOLSTER: holster = data[0];
                CFG_WINDOW:  window = data;
                CFG_THRESH:  threshold = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Returns 1 when a contact on filtered slot s is reported
        function bit decide_report(int s, logic [15:0] x, logic [15:0] y,
                                   logic [1:0] kind, logic [31:0] now);
            logic [31:0] d;
            longint unsigned ddx;
            longint unsigned ddy;
            longint unsigned thr;
            if (kind == KIND_FINGER || holster)
            begin
                pad_state = MODE_FINGER;
                return 1'b1;
            end
            if (kind == KIND_UNKNOWN)
                return 1'b1;
            case (pad_state)
                MODE_INIT:
                begin
                    pad_state = MODE_GLOVE;
                    return 1'b1;
                end
                MODE_FINGER:
                begin
                    // wrapped difference read as signed; must be positive and in window
                    d = now - lift_time[s];
                    if (d != 32'd0 && !d[31] && d <= {16'd0, window})
                        lift_time[s] = now;
                    else
                    begin
                        pad_state = MODE_ZERO;
                        to_zero++;
                    end
                    return 1'b0;
                end
                MODE_ZERO:
                begin
                    if (!anchor_ok[s])
                    begin
                        anchor_ok[s] = 1'b1;
                        anchor_px[s] = x;
                        anchor_py[s] = y;
                    end
                    else
                    begin
                        ddx = (anchor_px[s] > x) ? anchor_px[s] - x : x - anchor_px[s];
                        ddy = (anchor_py[s] > y) ? anchor_py[s] - y : y - anchor_py[s];
                        thr = threshold;
                        if (ddx * ddx + ddy * ddy >= thr * thr)
                        begin
                            pad_state = MODE_GLOVE;
                            to_glove++;
                        end
                    end
                    return 1'b0;
                end
                default: return 1'b1;
            endcase
        endfunction

        function void note_input(touch_beat_t b);
            touch_result_t r;
            r = '0;
            if (b.action)
            begin
                for (int i = 0; i < NFILT; i++)
                begin
                    anchor_ok[i] = 1'b0;
                    anchor_px[i] = '0;
                    anchor_py[i] = '0;
                    if (pad_state == MODE_FINGER)
                        lift_time[i] = b.t;
                end
                for (int i = 0; i < NSLOTS; i++)
                begin
                    r = '0;
                    r.slot   = 4'(i);
                    r.status = (i == 0) ? ST_RELEASE : ST_NONE;
                    r.last   = (i == NSLOTS - 1);
                    expected_results.push_back(r);
                end
                releases++;
                items++;
                return;
            end
            // out-of-range slot: dropped without a result
            if (b.slot >= NSLOTS)
                return;
            items++;
            r.slot = b.slot;
            r.last = 1'b1;
            if (b.x == 16'd0 && b.y == 16'd0)
                r.status = ST_NONE;
            else if (b.slot < NFILT && !decide_report(int'(b.slot), b.x, b.y, b.kind, b.t))
            begin
                r.status = ST_NONE;
                suppressed++;
            end
            else
            begin
                r.x = b.x;
                r.y = b.y;
                r.p = b.p;
                r.status = ST_PRESS;
                presses++;
            end
            expected_results.push_back(r);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            if (errors <= 40)
                $display("ERROR t=%0t beat %0d: %s got %0h expected %0h",
                         $time, checked, what, got, want);
        endtask

        task check_result(touch_result_t got);
            touch_result_t want;
            checked++;
            if (expected_results.size() == 0)
            begin
                report_mismatch("result beat with nothing pending, slot", got.slot, 0);
                return;
            end
            want = expected_results.pop_front();
            if (got.slot !== want.slot)     report_mismatch("out_slot", got.slot, want.slot);
            if (got.x !== want.x)           report_mismatch("out_x", got.x, want.x);
            if (got.y !== want.y)           report_mismatch("out_y", got.y, want.y);
            if (got.p !== want.p)           report_mismatch("out_pressure", got.p, want.p);
            if (got.status !== want.status) report_mismatch("status", got.status, want.status);
            if (got.last !== want.last)     report_mismatch("last", got.last, want.last);
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic                  action;
    logic [SLOT_W-1:0]     slot;
    logic [POS_W-1:0]      pos_x;
    logic [POS_W-1:0]      pos_y;
    logic [PRESS_W-1:0]    pressure;
    logic [1:0]            contact_kind;
    logic [TIME_W-1:0]     time_ms;
    logic                  out_valid;
    logic                  out_stall;
    logic [SLOT_W-1:0]     out_slot;
    logic [POS_W-1:0]      out_x;
    logic [POS_W-1:0]      out_y;
    logic [PRESS_W-1:0]    out_pressure;
    logic [1:0]            status;
    logic                  last;

    touch_filter_scoreboard sb;
    logic [31:0] now_ms;
    bit          idle_on;
    int          settings;

    touch_glove_rejection_filter uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .slot         (slot),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pressure     (pressure),
        .contact_kind (contact_kind),
        .time_ms      (time_ms),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_slot     (out_slot),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_pressure (out_pressure),
        .status       (status),
        .last         (last)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // Result side: check accepted beats, stall in random bursts
    initial
    begin
        int stall_left;
        touch_result_t got;
        stall_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                got = '{out_slot, out_x, out_y, out_pressure, status, last};
                sb.check_result(got);
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 13) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    function automatic touch_beat_t mk(input logic act, input int s, input int x, input int y,
                                       input int p, input logic [1:0] k);
        touch_beat_t b;
        b.action = act;
        b.slot   = 4'(s);
        b.x      = 16'(x);
        b.y      = 16'(y);
        b.p      = 16'(p);
        b.kind   = k;
        b.t      = now_ms;
        return b;
    endfunction

    function automatic logic [1:0] glove_kind();
        return ($urandom_range(0, 1) == 0) ? KIND_GLOVE : KIND_STYLUS;
    endfunction

    function automatic int pick_slot();
        return ($urandom_range(0, 4) == 0) ? $urandom_range(4, 9) : $urandom_range(0, 3);
    endfunction

    // Present one beat, with an optional idle burst first, and wait for acceptance
    task automatic drive_beat(input touch_beat_t b);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= b.action;
        slot         <= b.slot;
        pos_x        <= b.x;
        pos_y        <= b.y;
        pressure     <= b.p;
        contact_kind <= b.kind;
        time_ms      <= b.t;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_input(b);
    endtask

    // Sometimes slip a random beat ahead of the intended one
    task automatic push_beat(input touch_beat_t b);
        touch_beat_t z;
        if ($urandom_range(0, 7) == 0)
        begin
            z = '0;
            z.action = ($urandom_range(0, 9) == 0);
            z.slot   = 4'($urandom);
            if ($urandom_range(0, 3) != 0)
            begin
                z.x = 16'($urandom);
                z.y = 16'($urandom);
            end
            z.p    = 16'($urandom);
            z.kind = 2'($urandom);
            if ($urandom_range(0, 3) == 0)
                now_ms = $urandom;
            z.t = now_ms;
            drive_beat(z);
        end
        drive_beat(b);
    endtask

    task automatic cfg_write(input cfg_idx_t idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    // Write all registers (holster with junk upper bits) plus the spare index
    task automatic apply_config(input logic h, input logic [15:0] win, input logic [15:0] thr);
        cfg_write(CFG_SPARE, 16'($urandom));
        cfg_write(CFG_HOLSTER, {15'($urandom), h});
        cfg_write(CFG_WINDOW, win);
        cfg_write(CFG_THRESH, thr);
        cfg_we <= 1'b0;
        settings++;
    endtask

    // Drain every pending result, then let any dropped beat clear the pipeline
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic run_directed();
        now_ms = 32'd100;
        drive_beat(mk(0, 0, 200, 300, 1234, KIND_GLOVE));       // glove from init mode
        drive_beat(mk(0, 1, 65535, 65535, 65535, KIND_FINGER)); // finger, field maxima
        drive_beat(mk(0, 2, 0, 0, 77, KIND_FINGER));            // empty slot
        drive_beat(mk(0, 3, 5, 0, 0, KIND_UNKNOWN));            // unknown kind keeps mode
        drive_beat(mk(0, 9, 1, 1, 9, KIND_STYLUS));             // unfiltered slot
        drive_beat(mk(0, 15, 10, 10, 10, KIND_FINGER));         // slot out of range
        now_ms = 32'd1000;
        drive_beat(mk(1, 0, 0, 0, 0, KIND_FINGER));             // release stamps
        now_ms = 32'd1500;
        drive_beat(mk(0, 0, 40, 40, 1, KIND_STYLUS));           // exactly at window edge
        now_ms = 32'd2001;
        drive_beat(mk(0, 0, 40, 40, 1, KIND_GLOVE));            // one past window
        drive_beat(mk(0, 1, 100, 100, 2, KIND_GLOVE));          // anchor latch
        drive_beat(mk(0, 1, 129, 100, 3, KIND_GLOVE));          // just short of threshold
        drive_beat(mk(0, 1, 130, 100, 4, KIND_GLOVE));          // exactly threshold
        drive_beat(mk(0, 1, 130, 100, 5, KIND_STYLUS));         // glove mode reports
        now_ms = 32'd3000;
        drive_beat(mk(0, 2, 7, 8, 6, KIND_FINGER));
        drive_beat(mk(1, 0, 0, 0, 0, KIND_FINGER));
        drive_beat(mk(0, 2, 7, 8, 6, KIND_GLOVE));              // zero time difference
        now_ms = 32'd5000;
        drive_beat(mk(0, 0, 9, 9, 9, KIND_FINGER));
        drive_beat(mk(1, 0, 0, 0, 0, KIND_FINGER));
        now_ms = 32'd4000;
        drive_beat(mk(0, 3, 9, 9, 9, KIND_GLOVE));              // time went backwards
        drive_beat(mk(0, 0, 0, 65535, 0, KIND_GLOVE));          // anchor at an edge
        drive_beat(mk(0, 0, 65535, 0, 0, KIND_STYLUS));         // largest move
        now_ms = 32'hFFFF_FFFF;
        drive_beat(mk(1, 0, 0, 0, 0, KIND_FINGER));             // release in glove mode
        drive_beat(mk(0, 1, 3, 3, 3, KIND_FINGER));
        now_ms = 32'hFFFF_FF00;
        drive_beat(mk(1, 0, 0, 0, 0, KIND_FINGER));
        now_ms = 32'h0000_0010;
        drive_beat(mk(0, 1, 3, 3, 3, KIND_GLOVE));              // window across time wrap
    endtask

    // Finger touches, release, gloves around the window, anchor moves, then reports
    task automatic run_episode();
        int n;
        int s;
        int sel;
        int d;
        int thr;
        int ax;
        int ay;
        int nx;
        int ny;
        int unsigned win;
        int unsigned gap;
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
        begin
            now_ms += $urandom_range(0, 40);
            push_beat(mk(0, pick_slot(), $urandom_range(1, 65535), $urandom_range(0, 65535),
                         $urandom_range(0, 65535), KIND_FINGER));
        end
        if ($urandom_range(0, 3) != 0)
        begin
            now_ms += $urandom_range(0, 40);
            push_beat(mk(1, $urandom_range(0, 15), 0, 0, 0, 2'($urandom)));
        end

        // glove contacts near the release window
        s = $urandom_range(0, 3);
        win = sb.window;
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 9);
            case (sel)
                0: gap = 0;
                1: gap = win;
                2: gap = win + 1;
                3: gap = (win == 0) ? 0 : win - 1;
                4: gap = 32'hFFFF_FF00 + $urandom_range(0, 255);
                5: gap = $urandom;
                default: gap = $urandom_range(1, (win == 0) ? 1 : win);
            endcase
            now_ms += gap;
            push_beat(mk(0, s, $urandom_range(1, 65535), $urandom_range(0, 65535),
                         $urandom_range(0, 65535), glove_kind()));
            if ($urandom_range(0, 7) == 0)
                push_beat(mk(0, s, $urandom_range(1, 65535), $urandom_range(0, 65535),
                             $urandom_range(0, 65535), KIND_UNKNOWN));
        end

        // anchor and moves around the threshold
        s = $urandom_range(0, 3);
        thr = sb.threshold;
        ax = $urandom_range(0, 65535);
        ay = $urandom_range(1, 65535);
        if ($urandom_range(0, 3) == 0)
            ax = ($urandom_range(0, 1) == 0) ? 0 : 65535;
        now_ms += $urandom_range(0, 20);
        push_beat(mk(0, s, ax, ay, $urandom_range(0, 65535), glove_kind()));
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 4);
            case (sel)
                0: d = thr;
                1: d = (thr > 0) ? thr - 1 : 0;
                2: d = $urandom_range(0, thr);
                3: d = $urandom_range(0, 65535);
                default: d = (thr * 707) / 1000;
            endcase
            nx = (ax >= d) ? ax - d : ax + d;
            if (nx > 65535) nx = 65535;
            ny = ay;
            if (sel == 4)
            begin
                ny = (ay >= d) ? ay - d : ay + d;
                if (ny > 65535) ny = 65535;
            end
            if ($urandom_range(0, 5) == 0)
                s = $urandom_range(0, 3);
            now_ms += $urandom_range(0, 20);
            push_beat(mk(0, s, nx, ny, $urandom_range(0, 65535), glove_kind()));
        end

        // whatever the pad now accepts
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
        begin
            now_ms += $urandom_range(0, 60);
            push_beat(mk(0, pick_slot(), $urandom_range(0, 65535), $urandom_range(1, 65535),
                         $urandom_range(0, 65535), 2'($urandom_range(0, 3))));
        end
    endtask

    task automatic random_part(input int count);
        int target;
        target = sb.items + count;
        while (sb.items < target) run_episode();
    endtask

    // Main sequence
    initial
    begin
        sb = new();
        settings = 0;
        idle_on = 1'b1;
        now_ms = '0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_HOLSTER;
        cfg_data = '0;
        in_valid = 1'b0;
        action = 1'b0;
        slot = '0;
        pos_x = '0;
        pos_y = '0;
        pressure = '0;
        contact_kind = KIND_FINGER;
        time_ms = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults from reset
        run_directed();
        settle();

        // window and threshold at zero
        apply_config(1'b0, 16'd0, 16'd0);
        now_ms = $urandom;
        random_part(60);
        settle();

        // window and threshold at maximum
        apply_config(1'b0, 16'hFFFF, 16'hFFFF);
        random_part(60);
        settle();

        // holster cover on
        apply_config(1'b1, 16'($urandom), 16'($urandom));
        random_part(40);
        settle();

        // moderate random settings
        apply_config(1'b0, 16'($urandom_range(1, 2000)), 16'($urandom_range(1, 300)));
        random_part(80);
        settle();

        // closing stretch at full rate with reset-like values
        idle_on = 1'b0;
        apply_config(1'b0, WINDOW_RST, THRESHOLD_RST);
        random_part(80);
        settle();

        $display("Covered %0d counted beats (%0d releases) over %0d register settings.",
                 sb.items, sb.releases, settings);
        $display("Checked %0d result beats: %0d presses, %0d suppressed, %0d to zero, %0d to glove.",
                 sb.checked, sb.presses, sb.suppressed, sb.to_zero, sb.to_glove);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### touch_glove_rejection_filter.f
design/tgrf_pkg.sv
design/tgrf_judge.sv
design/touch_glove_rejection_filter.sv
design/tgrf_checker.sv
sim/tb_touch_glove_rejection_filter.sv
